// ===== hw/rtl/silu_activation_unit_assert.svh =====
// Assertion macros for the SiLU activation unit.
// Used by silu_activation_unit.sv; no other dependencies.
`ifndef SILU_ACTIVATION_UNIT_ASSERT_SVH
`define SILU_ACTIVATION_UNIT_ASSERT_SVH

// Checked only outside reset.
`define SILU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SILU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/silu_pkg.sv =====
// Constants shared by the SiLU activation unit: log2(e) and the 2^(k/16) table.
// No dependencies.
`timescale 1ns / 1ps

package silu_pkg;

  localparam int LOG2E_W  = 17;
  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

  localparam int TAB_W    = 18;
  localparam int TAB_N    = 17;
  localparam int IDX_W    = 4;
  localparam int TIDX_W   = 5;
  localparam int F16_W    = 16;
  localparam int INTERP_W = 12;
  localparam int BASE_W   = 17;
  localparam int DELTA_W  = 13;
  localparam int RSH_W    = 5;

  // e is forced to zero at or below this exponent
  localparam int E_ZERO_N = -24;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // 2^(k/16) in Q.16
  localparam logic [TAB_W-1:0] POW2_TAB [0:TAB_N-1] = '{
    18'd65536,  18'd68438,  18'd71468,  18'd74632,
    18'd77936,  18'd81386,  18'd84990,  18'd88752,
    18'd92682,  18'd96785,  18'd101070, 18'd105545,
    18'd110218, 18'd115097, 18'd120193, 18'd125515,
    18'd131072
  };

endpackage

// ===== hw/rtl/silu_activation_unit.sv =====
// Throughput: one transfer per cycle while the output is not stalled.
// Five front stages, then one quotient bit per stage, then the output register.
// A stall at the output freezes every stage; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Top level of the SiLU activation unit; depends on silu_pkg and the assert macro header.
`timescale 1ns / 1ps
`include "silu_activation_unit_assert.svh"

module silu_activation_unit
  import silu_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,  // [DW-1:0] sample_in
  input  logic                                      s_axis_tlast,  // last_in
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]   m_axis_tdata,  // [DW-1:0] sample_out
  output logic                                      m_axis_tlast   // last_out
);

  localparam int TDW  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int SFR  = FRAC_BITS + 16;          // fraction bits of t
  localparam int TW   = DATA_WIDTH + LOG2E_W;    // x * log2(e), signed
  localparam int NRAW = DATA_WIDTH + 1 - FRAC_BITS;
  localparam int NBW  = ((NRAW > 2) ? NRAW : 2) + 7;
  localparam int TXW  = SFR + NBW;
  localparam int SHW  = $clog2(DATA_WIDTH);
  localparam int EW   = DATA_WIDTH + 16;
  localparam int NW   = DATA_WIDTH + 17;
  localparam int QW   = DATA_WIDTH;

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW - 1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW - 1){1'b0}}};

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 1: x * log2(e)
  logic                         s1_valid;
  logic signed [TW-1:0]         s1_prod;
  logic signed [DATA_WIDTH-1:0] s1_x;
  logic                         s1_last;
  logic signed [DATA_WIDTH-1:0] x_in;

  assign x_in = s_axis_tdata[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= TW'(x_in) * $signed({1'b0, LOG2E_Q16});
      s1_x    <= x_in;
      s1_last <= s_axis_tlast;
    end
  end

  // ---------------- stage 2: split t = -x*log2(e), table lookup
  logic signed [TXW-1:0]        t_ext;
  logic [F16_W-1:0]             f16;
  logic [IDX_W-1:0]             tab_k;
  logic [TAB_W-1:0]             tab_lo;
  logic [TAB_W-1:0]             tab_hi;
  logic [TAB_W-1:0]             tab_diff;

  logic                         s2_valid;
  logic signed [NBW-1:0]        s2_n;
  logic [INTERP_W-1:0]          s2_r;
  logic [BASE_W-1:0]            s2_base;
  logic [DELTA_W-1:0]           s2_delta;
  logic signed [DATA_WIDTH-1:0] s2_x;
  logic                         s2_last;

  always_comb begin
    t_ext    = -(TXW'(s1_prod));
    f16      = t_ext[SFR-1:FRAC_BITS];
    tab_k    = f16[F16_W-1:INTERP_W];
    tab_lo   = POW2_TAB[TIDX_W'(tab_k)];
    tab_hi   = POW2_TAB[TIDX_W'(tab_k) + TIDX_W'(1)];
    tab_diff = tab_hi - tab_lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n     <= t_ext[TXW-1:SFR];
      s2_r     <= f16[INTERP_W-1:0];
      s2_base  <= tab_lo[BASE_W-1:0];
      s2_delta <= tab_diff[DELTA_W-1:0];
      s2_x     <= s1_x;
      s2_last  <= s1_last;
    end
  end

  // ---------------- stage 3: interpolate 2^f, classify exponent
  logic [DELTA_W+INTERP_W-1:0]  interp;
  logic [NBW-1:0]               n_neg;

  logic                         s3_valid;
  logic [BASE_W-1:0]            s3_p;
  logic                         s3_zero;   // quotient rounds to zero
  logic                         s3_ezero;  // e underflows to zero
  logic                         s3_left;
  logic [SHW-1:0]               s3_lsh;
  logic [RSH_W-1:0]             s3_rsh;
  logic signed [DATA_WIDTH-1:0] s3_x;
  logic                         s3_last;

  always_comb begin
    interp = DELTA_W'(s2_delta) * (DELTA_W + INTERP_W)'(s2_r);
    n_neg  = -s2_n;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p     <= s2_base + BASE_W'(interp >> INTERP_W);
      s3_zero  <= (s2_n >= NBW'(DATA_WIDTH));
      s3_ezero <= (s2_n <= NBW'(E_ZERO_N));
      s3_left  <= !s2_n[NBW-1];
      s3_lsh   <= s2_n[SHW-1:0];
      s3_rsh   <= n_neg[RSH_W-1:0];
      s3_x     <= s2_x;
      s3_last  <= s2_last;
    end
  end

  // ---------------- stage 4: e = 2^n * 2^f, |x|
  logic [EW-1:0]                e_val;

  logic                         s4_valid;
  logic [EW-1:0]                s4_e;
  logic [DATA_WIDTH-1:0]        s4_abs;
  logic                         s4_neg;
  logic                         s4_zero;
  logic                         s4_last;

  always_comb begin
    priority if (s3_zero || s3_ezero) begin
      e_val = '0;
    end else if (s3_left) begin
      e_val = EW'(s3_p) << s3_lsh;
    end else begin
      e_val = EW'(s3_p >> s3_rsh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_e    <= e_val;
      s4_abs  <= s3_x[DATA_WIDTH-1] ? DATA_WIDTH'(-s3_x) : DATA_WIDTH'(s3_x);
      s4_neg  <= s3_x[DATA_WIDTH-1];
      s4_zero <= s3_zero;
      s4_last <= s3_last;
    end
  end

  // ---------------- divider: stage 0 loads d and the rounded dividend
  logic [NW-1:0] dv_rem   [0:QW];
  logic [NW-1:0] dv_den   [0:QW];
  logic [QW-1:0] dv_q     [0:QW];
  logic          dv_neg   [0:QW];
  logic          dv_last  [0:QW];
  logic          dv_valid [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0]  <= NW'(ONE_Q16) + NW'(s4_e);
      // (|x| << 16) + d/2, with d/2 = 2^15 + e/2
      dv_rem[0]  <= s4_zero ? '0 :
                    NW'({s4_abs, 16'h0000}) + NW'(s4_e >> 1) + NW'(HALF_Q16);
      dv_q[0]    <= '0;
      dv_neg[0]  <= s4_neg;
      dv_last[0] <= s4_last;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[j]  <= dv_den[j-1];
        dv_neg[j]  <= dv_neg[j-1];
        dv_last[j] <= dv_last[j-1];
        if ((dv_rem[j-1] >> B) >= dv_den[j-1]) begin
          dv_rem[j]  <= dv_rem[j-1] - (dv_den[j-1] << B);
          dv_q[j]    <= dv_q[j-1] | (QW'(1) << B);
        end else begin
          dv_rem[j]  <= dv_rem[j-1];
          dv_q[j]    <= dv_q[j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (en) begin
        dv_valid[j] <= dv_valid[j-1];
      end
    end
  end

  // ---------------- output register: sign and saturation
  logic [QW-1:0] q_fin;
  logic [QW-1:0] y_val;

  always_comb begin
    q_fin = dv_q[QW];
    priority if (dv_neg[QW]) begin
      y_val = (q_fin > NEG_MAG) ? NEG_MAG : -q_fin;
    end else if (q_fin > POS_MAX) begin
      y_val = POS_MAX;
    end else begin
      y_val = q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= TDW'(y_val);
      m_axis_tlast <= dv_last[QW];
    end
  end

  // ---------------- valid chain of the front stages and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      dv_valid[0]   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= s_axis_tvalid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      dv_valid[0]   <= s4_valid;
      m_axis_tvalid <= dv_valid[QW];
    end
  end

  // ---------------- assertions
  `SILU_ASSERT_ALWAYS(a_rst_clears_out, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  `SILU_ASSERT(a_in_enters, clk, rst, s_axis_tvalid && s_axis_tready |=> s1_valid, "accepted transfer lost at stage 1")

  `SILU_ASSERT(a_div_rem, clk, rst, dv_valid[QW] |-> (dv_rem[QW] < dv_den[QW]), "final remainder not below divisor")

  `SILU_ASSERT(a_pos_sign, clk, rst, dv_valid[QW] && !dv_neg[QW] && en |=> !m_axis_tdata[DATA_WIDTH-1], "negative result for non-negative input")

endmodule
